// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the spring force RTL; clocked on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SBF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbf assertion failed");

// Expression must never be true outside reset.
`define SBF_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("sbf forbidden condition seen");

`endif

// ===== rtl/sbf_pkg.sv =====
// Shared types and constants of the spring / bungee force block.
package sbf_pkg;

  localparam int unsigned AXES       = 3;
  localparam int unsigned SQRT_STEPS = 33;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  localparam logic [1:0] REG_SPRING_CONSTANT = 2'd0;
  localparam logic [1:0] REG_REST_LENGTH     = 2'd1;
  localparam logic [1:0] REG_SPRING_MODE     = 2'd2;

  localparam logic MODE_SPRING = 1'b0;
  localparam logic MODE_BUNGEE = 1'b1;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [AXES-1:0][31:0] ad;      // |d| per axis
    logic [AXES-1:0]       pos;     // d > 0, force goes negative
    logic [AXES-1:0]       zero;    // component forced to zero
    logic [32:0]           len;     // floor(sqrt(sum d^2))
    logic [32:0]           mag;     // stretch magnitude
    logic                  applied;
  } job_t;

endpackage

// ===== rtl/sbf_front.sv =====
// Front pipeline: difference vector, length by digit-serial square root, stretch.
module sbf_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           rest_length,
  input  logic                  spring_mode,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0][31:0]      pos_self,
  input  logic [2:0][31:0]      pos_other,
  output logic                  job_valid,
  input  logic                  job_ready,
  output sbf_pkg::job_t         job
);

  `include "assert_macros.svh"

  typedef struct packed {
    logic [65:0]      s;
    logic [32:0]      root;
    logic [34:0]      rem;
    logic [2:0][31:0] ad;
    logic [2:0]       pos;
  } sq_t;

  function automatic sq_t sqrt_step(sq_t a, logic [1:0] pair);
    sq_t         r;
    logic [36:0] tmp;
    logic [36:0] trial;
    r     = a;
    tmp   = {a.rem, pair};
    trial = {2'b00, a.root[32:0], 2'b01};
    if (tmp >= trial) begin
      r.rem  = 35'(tmp - trial);
      r.root = {a.root[31:0], 1'b1};
    end else begin
      r.rem  = tmp[34:0];
      r.root = {a.root[31:0], 1'b0};
    end
    return r;
  endfunction

  logic ce;

  // stage A: differences
  logic             va_r;
  logic [2:0][31:0] ad_a_r, ad_a_nxt;
  logic [2:0]       pos_a_r, pos_a_nxt;
  // stage B: squares
  logic             vb_r;
  logic [2:0][63:0] sq_b_r;
  logic [2:0][31:0] ad_b_r;
  logic [2:0]       pos_b_r;
  // square root chain, entry 0 holds the sum
  logic             vs_r [0:sbf_pkg::SQRT_STEPS];
  sq_t              st_r [0:sbf_pkg::SQRT_STEPS];
  // stage M: job register
  logic             vm_r;
  sbf_pkg::job_t    job_r, job_nxt;

  assign ce       = !vm_r || job_ready;
  assign in_ready = ce;

  always_comb begin
    logic [32:0] d;
    for (int i = 0; i < 3; i++) begin
      d            = {pos_self[i][31], pos_self[i]} - {pos_other[i][31], pos_other[i]};
      pos_a_nxt[i] = !d[32] && (d != 33'd0);
      ad_a_nxt[i]  = d[32] ? 32'(33'd0 - d) : d[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r     <= 1'b0;
      vb_r     <= 1'b0;
      vs_r[0]  <= 1'b0;
    end else if (ce) begin
      va_r     <= in_valid;
      vb_r     <= va_r;
      vs_r[0]  <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ad_a_r  <= ad_a_nxt;
      pos_a_r <= pos_a_nxt;
      for (int i = 0; i < 3; i++) begin
        sq_b_r[i] <= ad_a_r[i] * ad_a_r[i];
      end
      ad_b_r  <= ad_a_r;
      pos_b_r <= pos_a_r;
      st_r[0].s    <= 66'(sq_b_r[0]) + 66'(sq_b_r[1]) + 66'(sq_b_r[2]);
      st_r[0].root <= '0;
      st_r[0].rem  <= '0;
      st_r[0].ad   <= ad_b_r;
      st_r[0].pos  <= pos_b_r;
    end
  end

  // one root bit per stage, most significant pair first
  for (genvar g = 0; g < sbf_pkg::SQRT_STEPS; g++) begin : g_sqrt
    localparam int B = sbf_pkg::SQRT_STEPS - 1 - g;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[g+1] <= 1'b0;
      end else if (ce) begin
        vs_r[g+1] <= vs_r[g];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        st_r[g+1] <= sqrt_step(st_r[g], st_r[g].s[2*B+1:2*B]);
      end
    end
  end

  always_comb begin
    sq_t         last;
    logic [32:0] len;
    logic [32:0] r_ext;
    last  = st_r[sbf_pkg::SQRT_STEPS];
    len   = last.root;
    r_ext = {1'b0, rest_length};
    job_nxt.ad      = last.ad;
    job_nxt.pos     = last.pos;
    job_nxt.len     = len;
    job_nxt.applied = (spring_mode == sbf_pkg::MODE_BUNGEE) ? (len > r_ext) : 1'b1;
    job_nxt.mag     = (len >= r_ext) ? (len - r_ext) : (r_ext - len);
    for (int i = 0; i < 3; i++) begin
      job_nxt.zero[i] = !job_nxt.applied || (len == 33'd0) || (last.ad[i] == 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (ce) begin
      vm_r <= vs_r[sbf_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = vm_r;
  assign job       = job_r;

  `SBF_ASSERT(a_slack_only_bungee, job_valid && !job.applied |-> spring_mode == sbf_pkg::MODE_BUNGEE)

endmodule

// ===== rtl/sbf_fifo.sv =====
// Short queue of classified items between front and back.
module sbf_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  sbf_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output sbf_pkg::job_t pop_data
);

  `include "assert_macros.svh"

  sbf_pkg::job_t                mem_r [0:sbf_pkg::FIFO_DEPTH-1];
  logic [sbf_pkg::FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [sbf_pkg::FIFO_AW:0]    cnt_r;
  logic                         push, pop;

  assign push_ready = cnt_r != (sbf_pkg::FIFO_AW+1)'(sbf_pkg::FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  `SBF_NEVER(a_cnt_bound, cnt_r > (sbf_pkg::FIFO_AW+1)'(sbf_pkg::FIFO_DEPTH))
  `SBF_ASSERT(a_ptr_gap, (wr_ptr_r - rd_ptr_r) == cnt_r[sbf_pkg::FIFO_AW-1:0])

endmodule

// ===== rtl/sbf_back.sv =====
// Back pipeline: k*|d|*stretch, pipelined divide by length, saturation.
module sbf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      spring_constant,
  input  logic             job_valid,
  output logic             job_ready,
  input  sbf_pkg::job_t    job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0][31:0] out_force,
  output logic             out_applied,
  output logic             out_sat
);

  `include "assert_macros.svh"

  typedef struct packed {
    logic [2:0]  pos;
    logic [2:0]  zero;
    logic [32:0] len;
    logic [32:0] mag;
    logic        applied;
  } ctl_t;

  typedef struct packed {
    logic [2:0][32:0] rem;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] q;
    logic [2:0]       over;
    ctl_t             c;
  } dv_t;

  function automatic dv_t div_step(dv_t a);
    dv_t         r;
    logic [33:0] t;
    r = a;
    for (int i = 0; i < 3; i++) begin
      t = {a.rem[i], a.lo[i][31]};
      r.lo[i] = {a.lo[i][30:0], 1'b0};
      if (t >= {1'b0, a.c.len}) begin
        r.rem[i] = 33'(t - {1'b0, a.c.len});
        r.q[i]   = {a.q[i][30:0], 1'b1};
      end else begin
        r.rem[i] = t[32:0];
        r.q[i]   = {a.q[i][30:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic ce;

  logic             v0_r, v1_r, v2_r;
  ctl_t             c0_r, c1_r, c2_r, c0_nxt;
  logic [2:0][63:0] kad_r;
  logic [2:0][63:0] plo_r, phi_r, kadh_r;
  logic [2:0][80:0] numq_r;
  logic             vd_r [0:sbf_pkg::DIV_STEPS];
  dv_t              dv_r [0:sbf_pkg::DIV_STEPS];
  dv_t              dv0_nxt;
  logic             vo_r;
  logic [2:0][31:0] force_r, force_nxt;
  logic             applied_r, sat_r, sat_nxt;

  assign ce        = !vo_r || out_ready;
  assign job_ready = ce;

  assign c0_nxt = '{pos: job.pos, zero: job.zero, len: job.len, mag: job.mag,
                    applied: job.applied};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      vd_r[0] <= 1'b0;
    end else if (ce) begin
      v0_r    <= job_valid;
      v1_r    <= v0_r;
      v2_r    <= v1_r;
      vd_r[0] <= v2_r;
    end
  end

  always_comb begin
    logic [80:0] nq;
    dv0_nxt.c = c2_r;
    for (int i = 0; i < 3; i++) begin
      nq                = numq_r[i];
      dv0_nxt.over[i]   = nq[80:32] >= {16'd0, c2_r.len};
      dv0_nxt.rem[i]    = nq[64:32];
      dv0_nxt.lo[i]     = nq[31:0];
      dv0_nxt.q[i]      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c0_r <= c0_nxt;
      c1_r <= c0_r;
      c2_r <= c1_r;
      for (int i = 0; i < 3; i++) begin
        kad_r[i]  <= spring_constant * job.ad[i];
        plo_r[i]  <= kad_r[i][31:0] * c0_r.mag[31:0];
        phi_r[i]  <= kad_r[i][63:32] * c0_r.mag[31:0];
        kadh_r[i] <= c0_r.mag[32] ? kad_r[i] : 64'd0;
        numq_r[i] <= 81'((97'(plo_r[i]) + {1'b0, phi_r[i], 32'd0}
                         + {1'b0, kadh_r[i], 32'd0}) >> 16);
      end
      dv_r[0] <= dv0_nxt;
    end
  end

  for (genvar g = 0; g < sbf_pkg::DIV_STEPS; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[g+1] <= 1'b0;
      end else if (ce) begin
        vd_r[g+1] <= vd_r[g];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        dv_r[g+1] <= div_step(dv_r[g]);
      end
    end
  end

  always_comb begin
    dv_t         f;
    logic [31:0] q;
    f       = dv_r[sbf_pkg::DIV_STEPS];
    sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = f.q[i];
      if (f.c.zero[i]) begin
        force_nxt[i] = '0;
      end else if (f.c.pos[i]) begin
        if (f.over[i] || q > 32'h8000_0000) begin
          sat_nxt      = 1'b1;
          force_nxt[i] = 32'h8000_0000;
        end else begin
          force_nxt[i] = 32'd0 - q;
        end
      end else begin
        if (f.over[i] || q[31]) begin
          sat_nxt      = 1'b1;
          force_nxt[i] = 32'h7FFF_FFFF;
        end else begin
          force_nxt[i] = q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (ce) begin
      vo_r <= vd_r[sbf_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      force_r   <= force_nxt;
      sat_r     <= sat_nxt;
      applied_r <= dv_r[sbf_pkg::DIV_STEPS].c.applied;
    end
  end

  assign out_valid   = vo_r;
  assign out_force   = force_r;
  assign out_applied = applied_r;
  assign out_sat     = sat_r;

  `SBF_ASSERT(a_slack_zero, out_valid && !out_applied |-> out_force == '0 && !out_sat)

endmodule

// ===== rtl/spring_bungee_force_unit.sv =====
// Top level of the spring / bungee force unit: config registers, front, queue, back.
//
// Usage:
//   in_*  : stream of items, each two 3D positions (self, other), signed Q16.16.
//   out_* : one result item per input item: force vector, applied and
//           saturated flags, in input order.
//   APB   : spring_constant at 0x0, rest_length at 0x4, spring_mode at 0x8.
//           Write only while no item is in flight.
// Throughput: one item per clock while out_tready stays high. The rate is
//   set by the two pipelines; the 33-stage square root (one root bit per
//   stage) and the 32-stage divider (one quotient bit per stage) are fully pipelined.
// Path: from accept to result an item passes 37 front stages, one queue slot
//   and 37 back stages.
// Reset: rst_n low clears all pipeline valids, empties the queue and sets the
//   registers to 0. No clearing pass; the block is ready the cycle after.
// Stall: when out_tready is low with a result waiting the back pipeline holds;
//   the front fills the 4-entry queue, and in_tready drops once its last stage fills.
module spring_bungee_force_unit (
  input  logic         clk,
  input  logic         rst_n,
  // self_x, self_y, self_z, other_x, other_y, other_z (32 bits each, from bit 0)
  input  logic [191:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // force_x, force_y, force_z (32 bits each, from bit 0)
  output logic [95:0]  out_tdata,
  // force_applied (bit 0), saturated (bit 1)
  output logic [1:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [31:0]      spring_constant_r;
  logic [31:0]      rest_length_r;
  logic             spring_mode_r;
  logic [1:0]       reg_idx;
  logic             wr_en;

  logic [2:0][31:0] pos_self, pos_other;
  logic             f_valid, f_ready, b_valid, b_ready;
  sbf_pkg::job_t    f_job, b_job;
  logic [2:0][31:0] force_v;
  logic             applied, sat;

  // APB register file, no wait states
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_constant_r <= '0;
      rest_length_r     <= '0;
      spring_mode_r     <= sbf_pkg::MODE_SPRING;
    end else if (wr_en) begin
      unique case (reg_idx)
        sbf_pkg::REG_SPRING_CONSTANT: spring_constant_r <= pwdata;
        sbf_pkg::REG_REST_LENGTH:     rest_length_r     <= pwdata;
        sbf_pkg::REG_SPRING_MODE:     spring_mode_r     <= pwdata[0];
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sbf_pkg::REG_SPRING_CONSTANT: prdata = spring_constant_r;
      sbf_pkg::REG_REST_LENGTH:     prdata = rest_length_r;
      sbf_pkg::REG_SPRING_MODE:     prdata = {31'd0, spring_mode_r};
      default:                      prdata = '0;
    endcase
  end

  // unpack positions, x in the lowest word
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_self[i]  = in_tdata[32*i +: 32];
      pos_other[i] = in_tdata[96 + 32*i +: 32];
    end
  end

  sbf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .rest_length (rest_length_r),
    .spring_mode (spring_mode_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .pos_self    (pos_self),
    .pos_other   (pos_other),
    .job_valid   (f_valid),
    .job_ready   (f_ready),
    .job         (f_job)
  );

  sbf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_job)
  );

  sbf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .spring_constant (spring_constant_r),
    .job_valid       (b_valid),
    .job_ready       (b_ready),
    .job             (b_job),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_force       (force_v),
    .out_applied     (applied),
    .out_sat         (sat)
  );

  assign out_tdata = {force_v[2], force_v[1], force_v[0]};
  assign out_tuser = {sat, applied};

endmodule
